/* hdl/float_to_decimal_ascii_macros.svh */
// Assertion macros used by the float to decimal text converter.
`ifndef FLOAT_TO_DECIMAL_ASCII_MACROS_SVH
`define FLOAT_TO_DECIMAL_ASCII_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FTDA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FTDA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/ftda_pkg.sv */
// Shared types and constants of the float to decimal text converter.
package ftda_pkg;

    localparam int MANT_W              = 24;
    localparam int INT_BITS            = 64;
    localparam int INT_DIGITS          = 20;
    localparam int INT_IDX_W           = $clog2(INT_DIGITS);
    localparam int INT_CNT_W           = $clog2(INT_BITS + 1);
    localparam int FRAC_CNT_W          = 6;
    localparam int DEF_FRACTION_DIGITS = 4;

    // Biased exponent thresholds.
    localparam logic [7:0] EXP_BIAS     = 8'd127;
    localparam logic [7:0] EXP_TINY     = 8'd91;
    localparam logic [7:0] EXP_HUGE     = 8'd191;
    localparam logic [7:0] EXP_INT_ONLY = 8'd150;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_POINT = 8'h2E;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef logic [3:0] bcd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_INT,
        ST_POINT,
        ST_FRAC
    } state_t;

    typedef struct packed {
        logic                 load;
        logic                 fill;
        logic [INT_CNT_W-1:0] nbits;
    } int_ctl_t;

    typedef struct packed {
        logic                 done;
        logic [INT_IDX_W-1:0] top;
    } int_stat_t;

    typedef struct packed {
        logic                  load;
        logic                  shift;
        logic [FRAC_CNT_W-1:0] nbits;
    } frac_ctl_t;

    typedef struct packed {
        logic done;
        logic any_nz;
        logic tail_zero;
    } frac_stat_t;

endpackage

/* hdl/ftda_int_bcd.sv */
// Bit-serial binary to BCD converter for the integer part, most significant bit first.
module ftda_int_bcd (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ftda_pkg::int_ctl_t                 ctl,
    input  logic [ftda_pkg::MANT_W-1:0]        mant,
    input  logic [ftda_pkg::INT_IDX_W-1:0]     sel,
    output ftda_pkg::int_stat_t                stat,
    output ftda_pkg::bcd_t                     digit
);

    ftda_pkg::bcd_t                      digits_reg [ftda_pkg::INT_DIGITS];
    ftda_pkg::bcd_t                      digits_next [ftda_pkg::INT_DIGITS];
    ftda_pkg::bcd_t                      adj [ftda_pkg::INT_DIGITS];
    ftda_pkg::bcd_t                      shifted [ftda_pkg::INT_DIGITS];
    logic [ftda_pkg::MANT_W-1:0]         bits_reg;
    logic [ftda_pkg::MANT_W-1:0]         bits_next;
    logic                                fill_reg;
    logic                                fill_next;
    logic [ftda_pkg::INT_CNT_W-1:0]      cnt_reg;
    logic [ftda_pkg::INT_CNT_W-1:0]      cnt_next;
    logic [ftda_pkg::INT_IDX_W-1:0]      top_reg;
    logic [ftda_pkg::INT_IDX_W-1:0]      top_next;
    logic [ftda_pkg::INT_IDX_W-1:0]      top_up;

    always_comb
    begin
        for (int i = 0; i < ftda_pkg::INT_DIGITS; i++)
        begin
            adj[i] = (digits_reg[i] >= 4'd5) ? digits_reg[i] + 4'd3 : digits_reg[i];
        end
        shifted[0] = {adj[0][2:0], bits_reg[ftda_pkg::MANT_W-1]};
        for (int i = 1; i < ftda_pkg::INT_DIGITS; i++)
        begin
            shifted[i] = {adj[i][2:0], adj[i-1][3]};
        end
    end

    assign top_up = top_reg + 1'b1;

    always_comb
    begin
        digits_next = digits_reg;
        bits_next   = bits_reg;
        fill_next   = fill_reg;
        cnt_next    = cnt_reg;
        top_next    = top_reg;
        if (ctl.load)
        begin
            for (int i = 0; i < ftda_pkg::INT_DIGITS; i++)
            begin
                digits_next[i] = '0;
            end
            bits_next = mant;
            fill_next = ctl.fill;
            cnt_next  = ctl.nbits;
            top_next  = '0;
        end
        else if (cnt_reg != '0)
        begin
            digits_next = shifted;
            bits_next   = {bits_reg[ftda_pkg::MANT_W-2:0], fill_reg};
            cnt_next    = cnt_reg - 1'b1;
            // The value gains at most one decimal digit per doubling.
            if (top_reg != ftda_pkg::INT_IDX_W'(ftda_pkg::INT_DIGITS - 1))
            begin
                if (shifted[top_up] != '0)
                begin
                    top_next = top_up;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            top_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            top_reg <= top_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
        bits_reg   <= bits_next;
        fill_reg   <= fill_next;
    end

    assign stat.done = (cnt_reg == '0);
    assign stat.top  = top_reg;
    assign digit     = digits_reg[sel];

endmodule

/* hdl/ftda_frac_bcd.sv */
// Bit-serial fraction scaler that builds the truncated fraction digits directly in BCD.
module ftda_frac_bcd #(
    parameter int FRACTION_DIGITS = ftda_pkg::DEF_FRACTION_DIGITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ftda_pkg::frac_ctl_t            ctl,
    input  logic [ftda_pkg::MANT_W-1:0]    mant,
    output ftda_pkg::frac_stat_t           stat,
    output ftda_pkg::bcd_t                 head
);

    ftda_pkg::bcd_t                      digits_reg [FRACTION_DIGITS];
    ftda_pkg::bcd_t                      digits_next [FRACTION_DIGITS];
    ftda_pkg::bcd_t                      halved [FRACTION_DIGITS];
    logic [FRACTION_DIGITS:0]            odd;
    logic [ftda_pkg::MANT_W-1:0]         bits_reg;
    logic [ftda_pkg::MANT_W-1:0]         bits_next;
    logic [ftda_pkg::FRAC_CNT_W-1:0]     cnt_reg;
    logic [ftda_pkg::FRAC_CNT_W-1:0]     cnt_next;
    logic                                tail_nz;

    // Each step adds the scale 10^n when the bit is set and then halves, all in BCD.
    always_comb
    begin
        odd[FRACTION_DIGITS] = bits_reg[0];
        for (int i = 0; i < FRACTION_DIGITS; i++)
        begin
            odd[i] = digits_reg[i][0];
        end
        for (int i = 0; i < FRACTION_DIGITS; i++)
        begin
            halved[i] = {1'b0, digits_reg[i][3:1]} + (odd[i+1] ? 4'd5 : 4'd0);
        end
    end

    always_comb
    begin
        tail_nz = 1'b0;
        for (int i = 0; i < FRACTION_DIGITS - 1; i++)
        begin
            tail_nz = tail_nz | (digits_reg[i] != '0);
        end
    end

    always_comb
    begin
        digits_next = digits_reg;
        bits_next   = bits_reg;
        cnt_next    = cnt_reg;
        if (ctl.load)
        begin
            for (int i = 0; i < FRACTION_DIGITS; i++)
            begin
                digits_next[i] = '0;
            end
            bits_next = mant;
            cnt_next  = ctl.nbits;
        end
        else if (cnt_reg != '0)
        begin
            digits_next = halved;
            bits_next   = {1'b0, bits_reg[ftda_pkg::MANT_W-1:1]};
            cnt_next    = cnt_reg - 1'b1;
        end
        else if (ctl.shift)
        begin
            digits_next[0] = '0;
            for (int i = 1; i < FRACTION_DIGITS; i++)
            begin
                digits_next[i] = digits_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
        bits_reg   <= bits_next;
    end

    assign head           = digits_reg[FRACTION_DIGITS-1];
    assign stat.done      = (cnt_reg == '0);
    assign stat.tail_zero = !tail_nz;
    assign stat.any_nz    = tail_nz | (digits_reg[FRACTION_DIGITS-1] != '0);

endmodule

/* hdl/float_to_decimal_ascii.sv */
// Top level of the converter from single-precision bits to decimal ASCII text.
//
// Input channel: float_bits with in_valid/in_stall; a transaction is taken when
// in_valid is high and in_stall is low. Output channel: one character per
// transaction on text_char, with is_last set on the final character of a number.
// One number is converted at a time; in_stall stays high from the transaction
// that brings a number until its last character has been loaded into the
// output register.
// The accepting edge loads both converters, which then shift through N bits,
// N the larger of the integer bit count (E+1 for an unbiased exponent E
// from 0 to 63, 64 above that, else 0) and the fraction bit count (23-E for E
// from -36 to 22, else 0); N is 64 at most. When both are done, the sequencer
// takes the index of the leading integer digit and moves on to the characters.
// Characters then leave at one per cycle while the receiver does not stall, up
// to 21 of them with the default fraction digit count.
// When the receiver stalls, the character held in the output register stays
// put and the sequencer waits. Reset empties the output register and returns
// the block to idle; no result is pending after reset.
`include "float_to_decimal_ascii_macros.svh"

module float_to_decimal_ascii #(
    parameter int FRACTION_DIGITS = ftda_pkg::DEF_FRACTION_DIGITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] float_bits,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  text_char,
    output logic        is_last
);

    ftda_pkg::state_t                    state_reg;
    ftda_pkg::state_t                    state_next;
    logic                                sign_reg;
    logic                                sign_next;
    logic [ftda_pkg::INT_IDX_W-1:0]      idx_reg;
    logic [ftda_pkg::INT_IDX_W-1:0]      idx_next;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic [7:0]                          char_reg;
    logic [7:0]                          char_next;
    logic                                last_reg;
    logic                                last_next;
    logic                                adv;
    logic                                emit;

    logic [7:0]                          exp_b;
    logic                                tiny;
    logic                                huge;
    logic [ftda_pkg::MANT_W-1:0]         mant;
    logic [ftda_pkg::INT_CNT_W-1:0]      int_nbits;
    logic [ftda_pkg::FRAC_CNT_W-1:0]     frac_nbits;

    ftda_pkg::int_ctl_t                  int_ctl;
    ftda_pkg::int_stat_t                 int_stat;
    ftda_pkg::bcd_t                      int_digit;
    ftda_pkg::frac_ctl_t                 frac_ctl;
    ftda_pkg::frac_stat_t                frac_stat;
    ftda_pkg::bcd_t                      frac_head;

    assign exp_b = float_bits[30:23];
    assign tiny  = (exp_b < ftda_pkg::EXP_TINY);
    assign huge  = (exp_b >= ftda_pkg::EXP_HUGE);
    assign mant  = huge ? '1 : {1'b1, float_bits[22:0]};

    always_comb
    begin
        if (huge)
        begin
            int_nbits = ftda_pkg::INT_CNT_W'(ftda_pkg::INT_BITS);
        end
        else if (!tiny && (exp_b >= ftda_pkg::EXP_BIAS))
        begin
            int_nbits = ftda_pkg::INT_CNT_W'(exp_b - ftda_pkg::EXP_BIAS + 8'd1);
        end
        else
        begin
            int_nbits = '0;
        end
        if (!tiny && (exp_b < ftda_pkg::EXP_INT_ONLY))
        begin
            frac_nbits = ftda_pkg::FRAC_CNT_W'(ftda_pkg::EXP_INT_ONLY - exp_b);
        end
        else
        begin
            frac_nbits = '0;
        end
    end

    assign adv = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ftda_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ftda_pkg::ST_CONV;
                end
            end
            ftda_pkg::ST_CONV:
            begin
                if (int_stat.done && frac_stat.done)
                begin
                    state_next = sign_reg ? ftda_pkg::ST_SIGN : ftda_pkg::ST_INT;
                end
            end
            ftda_pkg::ST_SIGN:
            begin
                if (adv)
                begin
                    state_next = ftda_pkg::ST_INT;
                end
            end
            ftda_pkg::ST_INT:
            begin
                if (adv && (idx_reg == '0))
                begin
                    state_next = frac_stat.any_nz ? ftda_pkg::ST_POINT : ftda_pkg::ST_IDLE;
                end
            end
            ftda_pkg::ST_POINT:
            begin
                if (adv)
                begin
                    state_next = ftda_pkg::ST_FRAC;
                end
            end
            ftda_pkg::ST_FRAC:
            begin
                if (adv && frac_stat.tail_zero)
                begin
                    state_next = ftda_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ftda_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        int_ctl.load   = 1'b0;
        int_ctl.fill   = huge;
        int_ctl.nbits  = int_nbits;
        frac_ctl.load  = 1'b0;
        frac_ctl.shift = 1'b0;
        frac_ctl.nbits = frac_nbits;
        emit           = 1'b0;
        char_next      = char_reg;
        last_next      = last_reg;
        idx_next       = idx_reg;
        sign_next      = sign_reg;
        case (state_reg)
            ftda_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    int_ctl.load  = 1'b1;
                    frac_ctl.load = 1'b1;
                    sign_next     = float_bits[31];
                end
            end
            ftda_pkg::ST_CONV:
            begin
                idx_next = int_stat.top;
            end
            ftda_pkg::ST_SIGN:
            begin
                if (adv)
                begin
                    emit      = 1'b1;
                    char_next = ftda_pkg::CHAR_MINUS;
                    last_next = 1'b0;
                end
            end
            ftda_pkg::ST_INT:
            begin
                if (adv)
                begin
                    emit      = 1'b1;
                    char_next = ftda_pkg::CHAR_ZERO + {4'b0000, int_digit};
                    last_next = (idx_reg == '0) && !frac_stat.any_nz;
                    if (idx_reg != '0)
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            ftda_pkg::ST_POINT:
            begin
                if (adv)
                begin
                    emit      = 1'b1;
                    char_next = ftda_pkg::CHAR_POINT;
                    last_next = 1'b0;
                end
            end
            ftda_pkg::ST_FRAC:
            begin
                if (adv)
                begin
                    emit           = 1'b1;
                    char_next      = ftda_pkg::CHAR_ZERO + {4'b0000, frac_head};
                    last_next      = frac_stat.tail_zero;
                    frac_ctl.shift = 1'b1;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (adv)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ftda_pkg::ST_IDLE;
            sign_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sign_reg      <= sign_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

    ftda_int_bcd u_int_bcd (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (int_ctl),
        .mant  (mant),
        .sel   (idx_reg),
        .stat  (int_stat),
        .digit (int_digit)
    );

    ftda_frac_bcd #(
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_frac_bcd (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (frac_ctl),
        .mant  (mant),
        .stat  (frac_stat),
        .head  (frac_head)
    );

    assign in_stall  = (state_reg != ftda_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign text_char = char_reg;
    assign is_last   = last_reg;

    `FTDA_ASSERT_NEXT(a_accept_starts_conv, clk, rst_n, in_valid && !in_stall, state_reg == ftda_pkg::ST_CONV, "accepted transaction did not start conversion")
    `FTDA_ASSERT_NOW(a_frac_has_digits, clk, rst_n, state_reg == ftda_pkg::ST_FRAC, frac_stat.any_nz, "fraction digits sent with nothing left to send")
    `FTDA_ASSERT_NOW(a_int_idx_in_range, clk, rst_n, state_reg == ftda_pkg::ST_INT, idx_reg <= int_stat.top, "integer digit index above the leading digit")
    `FTDA_ASSERT_NOW(a_last_ends_number, clk, rst_n, out_valid && is_last, (state_reg != ftda_pkg::ST_POINT) && (state_reg != ftda_pkg::ST_FRAC), "final character pending while the fraction is still being sent")

endmodule
